// ----- rtl/core/hsd_pkg.sv -----
// Shared types, constants and helper functions for the Hamming stream decoder.
`timescale 1ns / 1ps
package hsd_pkg;

   localparam int CW_BITS  = 80;
   localparam int CW_MAX   = 71;
   localparam int OB_BITS  = 72;
   localparam int DATA_MAX = 64;
   localparam int SYN_BITS = 7;

   typedef struct packed {
      logic [7:0] code_byte;
      logic       end_of_stream;
   } item_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       bit_corrected;
      logic       last_of_run;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_CHECK = 5'b00010,
      ST_FIX   = 5'b00100,
      ST_EMIT  = 5'b01000,
      ST_FLUSH = 5'b10000
   } state_type;

   function automatic logic [6:0] cw_len(input logic [2:0] sel);
      logic [6:0] n;
      unique case (sel)
         3'd0:    n = 7'd12;
         3'd1:    n = 7'd17;
         3'd2:    n = 7'd21;
         3'd3:    n = 7'd29;
         3'd4:    n = 7'd38;
         3'd5:    n = 7'd54;
         default: n = 7'd71;
      endcase
      return n;
   endfunction

   function automatic logic [6:0] data_len(input logic [2:0] sel);
      logic [6:0] d;
      unique case (sel)
         3'd0:    d = 7'd8;
         3'd1:    d = 7'd12;
         3'd2:    d = 7'd16;
         3'd3:    d = 7'd24;
         3'd4:    d = 7'd32;
         3'd5:    d = 7'd48;
         default: d = 7'd64;
      endcase
      return d;
   endfunction

   // Data bits in a shortened codeword of len bits.
   function automatic logic [6:0] tail_data_len(input logic [6:0] len);
      logic [6:0] p;
      p = 7'((len > 7'd0) ? 1 : 0) + 7'((len > 7'd1) ? 1 : 0) + 7'((len > 7'd3) ? 1 : 0)
        + 7'((len > 7'd7) ? 1 : 0) + 7'((len > 7'd15) ? 1 : 0)
        + 7'((len > 7'd31) ? 1 : 0) + 7'((len > 7'd63) ? 1 : 0);
      return len - p;
   endfunction

   // Gathers the bits at non-parity positions, oldest first.
   function automatic logic [DATA_MAX-1:0] data_of(input logic [CW_MAX-1:0] cw);
      logic [DATA_MAX-1:0] d;
      int                  idx;
      d   = '0;
      idx = 0;
      for (int p = 0; p < CW_MAX; p++) begin
         if (((p + 1) & p) != 0) begin
            d[idx] = cw[p];
            idx++;
         end
      end
      return d;
   endfunction

endpackage

// ----- rtl/core/hamming_stream_decoder_unit.sv -----
// Top level of the Hamming stream decoder with its configuration register.
//
// Channel | Ports                                                  | Beat when
// req     | req_push, req_full, req_code_byte, req_end_of_stream   | push & !full
// rsp     | rsp_pop, rsp_empty, rsp_data_byte, rsp_bit_corrected,  | pop & !empty
//         | rsp_last_of_run                                        |
// csr     | csr_valid, csr_ready, csr_block_size_sel               | valid & ready
//
// An input beat passes IDLE and CHECK in the decode sequencer, then FLUSH when it completes no codeword.
// Each completed codeword passes FIX and EMIT, which emits the data bytes it finishes one at a time.
// An end-of-stream beat moves the tail bits to EMIT, which emits the tail bytes before FLUSH.
// Reset is synchronous; it empties both queues and sets the block size select to 0.
// The sequencer stalls when the four-entry result queue is full.
`timescale 1ns / 1ps
module hamming_stream_decoder_unit import hsd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_code_byte,
   input  logic       req_end_of_stream,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_bit_corrected,
   output logic       rsp_last_of_run,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [2:0] csr_block_size_sel
);

   logic [2:0] sel_ff, sel_in;
   logic       item_valid, item_pop, rsp_full, rsp_wr;
   item_type   item;
   rsp_type    rsp_wdata, rsp_rdata;

   assign csr_ready = 1'b1;
   assign sel_in    = (csr_valid && csr_ready) ? csr_block_size_sel : sel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= 3'd0;
      end else begin
         sel_ff <= sel_in;
      end
   end

   hsd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (req_push),
      .full          (req_full),
      .code_byte     (req_code_byte),
      .end_of_stream (req_end_of_stream),
      .item_valid    (item_valid),
      .item          (item),
      .item_pop      (item_pop)
   );

   hsd_decode u_decode (
      .clock          (clock),
      .reset          (reset),
      .block_size_sel (sel_ff),
      .item_valid     (item_valid),
      .item           (item),
      .item_pop       (item_pop),
      .rsp_full       (rsp_full),
      .rsp_wr         (rsp_wr),
      .rsp_data       (rsp_wdata)
   );

   hsd_rsp_queue u_rsp (
      .clock   (clock),
      .reset   (reset),
      .wr      (rsp_wr),
      .wr_data (rsp_wdata),
      .q_full  (rsp_full),
      .empty   (rsp_empty),
      .pop     (rsp_pop),
      .rd_data (rsp_rdata)
   );

   assign rsp_data_byte     = rsp_rdata.data_byte;
   assign rsp_bit_corrected = rsp_rdata.bit_corrected;
   assign rsp_last_of_run   = rsp_rdata.last_of_run;

endmodule

// ----- rtl/core/hsd_front.sv -----
// Input queue that accepts code byte beats and marks end-of-stream items.
`timescale 1ns / 1ps
module hsd_front import hsd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] code_byte,
   input  logic       end_of_stream,
   output logic       item_valid,
   output item_type   item,
   input  logic       item_pop
);

   item_type   q_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push;

   assign full       = (cnt_ff == 2'd2);
   assign item_valid = (cnt_ff != 2'd0);
   assign item       = q_ff[rp_ff];
   assign do_push    = push && !full;

   always_comb begin
      wp_in  = wp_ff + 1'(do_push);
      rp_in  = rp_ff + 1'(item_pop);
      cnt_in = cnt_ff + 2'(do_push) - 2'(item_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wp_ff].code_byte     <= end_of_stream ? 8'd0 : code_byte;
         q_ff[wp_ff].end_of_stream <= end_of_stream;
      end
   end

endmodule

// ----- rtl/core/hsd_rsp_queue.sv -----
// Result queue that holds decoded byte beats until they are popped.
`timescale 1ns / 1ps
module hsd_rsp_queue import hsd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    wr,
   input  rsp_type wr_data,
   output logic    q_full,
   output logic    empty,
   input  logic    pop,
   output rsp_type rd_data
);

   rsp_type    q_ff [4];
   logic [1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       do_pop;

   assign q_full  = (cnt_ff == 3'd4);
   assign empty   = (cnt_ff == 3'd0);
   assign rd_data = q_ff[rp_ff];
   assign do_pop  = pop && !empty;

   always_comb begin
      wp_in  = wp_ff + 2'(wr);
      rp_in  = rp_ff + 2'(do_pop);
      cnt_in = cnt_ff + 3'(wr) - 3'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 2'd0;
         rp_ff  <= 2'd0;
         cnt_ff <= 3'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         q_ff[wp_ff] <= wr_data;
      end
   end

endmodule

// ----- rtl/core/hsd_decode.sv -----
// Decode sequencer: gathers codewords, corrects them and packs data bytes.
`timescale 1ns / 1ps
module hsd_decode import hsd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic [2:0] block_size_sel,
   input  logic       item_valid,
   input  item_type   item,
   output logic       item_pop,
   input  logic       rsp_full,
   output logic       rsp_wr,
   output rsp_type    rsp_data
);

   state_type            state_ff, state_in;
   logic [CW_BITS-1:0]   cw_ff, cw_in;
   logic [6:0]           cw_fill_ff, cw_fill_in;
   logic [OB_BITS-1:0]   ob_ff, ob_in, obm_ff, obm_in;
   logic [6:0]           ob_fill_ff, ob_fill_in;
   logic [SYN_BITS-1:0]  syn_ff, syn_in;
   logic                 eos_ff, eos_in, tail_ff, tail_in;
   logic                 held_v_ff, held_v_in;
   rsp_type              held_ff, held_in;

   logic [2:0]           sel;
   logic [6:0]           n;

   assign sel = (block_size_sel == 3'd7) ? 3'd6 : block_size_sel;
   assign n   = cw_len(sel);

   always_comb begin
      logic [SYN_BITS-1:0]  syn;
      logic [CW_MAX-1:0]    cwf;
      logic [DATA_MAX-1:0]  dv, dmask;
      logic [6:0]           cnt;
      logic                 mark;
      logic [7:0]           rev, byte_v;

      state_in   = state_ff;
      cw_in      = cw_ff;
      cw_fill_in = cw_fill_ff;
      ob_in      = ob_ff;
      obm_in     = obm_ff;
      ob_fill_in = ob_fill_ff;
      syn_in     = syn_ff;
      eos_in     = eos_ff;
      tail_in    = tail_ff;
      held_v_in  = held_v_ff;
      held_in    = held_ff;
      item_pop   = 1'b0;
      rsp_wr     = 1'b0;
      rsp_data   = held_ff;
      syn        = '0;
      cwf        = cw_ff[CW_MAX-1:0];
      dv         = '0;
      dmask      = '0;
      cnt        = '0;
      mark       = 1'b0;
      rev        = '0;
      byte_v     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               eos_in   = item.end_of_stream;
               if (!item.end_of_stream) begin
                  for (int k = 0; k < 8; k++) begin
                     rev[k] = item.code_byte[7-k];
                  end
                  cw_in      = cw_ff | (CW_BITS'(rev) << cw_fill_ff);
                  cw_fill_in = cw_fill_ff + 7'd8;
               end
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (cw_fill_ff >= n) begin
               for (int m = 0; m < CW_MAX; m++) begin
                  if (cw_ff[m] && (7'(m) < n)) begin
                     syn = syn ^ SYN_BITS'(m + 1);
                  end
               end
               syn_in   = syn;
               state_in = ST_FIX;
            end else if (eos_ff) begin
               cnt        = tail_data_len(cw_fill_ff);
               dmask      = (DATA_MAX'(1) << cnt) - DATA_MAX'(1);
               dv         = data_of(cw_ff[CW_MAX-1:0]) & dmask;
               ob_in      = ob_ff | (OB_BITS'(dv) << ob_fill_ff);
               ob_fill_in = ob_fill_ff + cnt;
               cw_in      = '0;
               cw_fill_in = '0;
               tail_in    = 1'b1;
               state_in   = ST_EMIT;
            end else begin
               state_in = ST_FLUSH;
            end
         end
         ST_FIX: begin
            if ((syn_ff != '0) && (syn_ff <= n)) begin
               cwf  = cw_ff[CW_MAX-1:0] ^ (CW_MAX'(1) << (syn_ff - 7'd1));
               mark = 1'b1;
            end
            cnt        = data_len(sel);
            dmask      = (DATA_MAX'(1) << cnt) - DATA_MAX'(1);
            dv         = data_of(cwf) & dmask;
            ob_in      = ob_ff | (OB_BITS'(dv) << ob_fill_ff);
            obm_in     = obm_ff | (mark ? (OB_BITS'(dmask) << ob_fill_ff) : '0);
            ob_fill_in = ob_fill_ff + cnt;
            cw_in      = cw_ff >> n;
            cw_fill_in = cw_fill_ff - n;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            if (ob_fill_ff >= 7'd8) begin
               if (!(held_v_ff && rsp_full)) begin
                  if (held_v_ff) begin
                     rsp_wr               = 1'b1;
                     rsp_data.last_of_run = 1'b0;
                  end
                  for (int k = 0; k < 8; k++) begin
                     byte_v[7-k] = ob_ff[k];
                  end
                  held_in.data_byte     = byte_v;
                  held_in.bit_corrected = |obm_ff[7:0];
                  held_in.last_of_run   = 1'b0;
                  held_v_in             = 1'b1;
                  ob_in                 = ob_ff >> 8;
                  obm_in                = obm_ff >> 8;
                  ob_fill_in            = ob_fill_ff - 7'd8;
               end
            end else if (tail_ff) begin
               ob_in      = '0;
               obm_in     = '0;
               ob_fill_in = '0;
               tail_in    = 1'b0;
               state_in   = ST_FLUSH;
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_FLUSH: begin
            if (held_v_ff) begin
               if (!rsp_full) begin
                  rsp_wr               = 1'b1;
                  rsp_data.last_of_run = 1'b1;
                  held_v_in            = 1'b0;
                  state_in             = ST_IDLE;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cw_ff      <= '0;
         cw_fill_ff <= '0;
         ob_ff      <= '0;
         obm_ff     <= '0;
         ob_fill_ff <= '0;
         eos_ff     <= 1'b0;
         tail_ff    <= 1'b0;
         held_v_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cw_ff      <= cw_in;
         cw_fill_ff <= cw_fill_in;
         ob_ff      <= ob_in;
         obm_ff     <= obm_in;
         ob_fill_ff <= ob_fill_in;
         eos_ff     <= eos_in;
         tail_ff    <= tail_in;
         held_v_ff  <= held_v_in;
      end
   end

   always_ff @(posedge clock) begin
      syn_ff  <= syn_in;
      held_ff <= held_in;
   end

endmodule
